>>> rtl/ssc_pkg.sv
// Shared types and constants of the segment/sphere clip pipeline.
`default_nettype none
package ssc_pkg;
   localparam int CW = 32;
   localparam int LIMBS = 5;
   localparam int MW = LIMBS * CW;
   localparam int PW = 2 * MW;
   localparam int SW = 200;
   localparam int STEPS = 31;
   localparam int KW = $clog2(STEPS);

   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] NO_HIT = 32'hC000_0000;
   localparam logic [31:0] INV_RADIUS_RESET = 32'h0100_0000;

   localparam logic [7:0] REG_INV_RADIUS = 8'd0;
   localparam logic [7:0] REG_CYL_MODE = 8'd1;

   typedef struct packed {
      logic a_in;
      logic b_in;
      logic both_hit;
   } case_type;

   typedef struct packed {
      logic valid;
      case_type cs;
      logic signed [SW-1:0] a;
      logic signed [SW-1:0] hs;
      logic signed [SW-1:0] fs;
      logic [30:0] ts;
      logic signed [SW-1:0] he;
      logic signed [SW-1:0] fe;
      logic [30:0] te;
   } step_type;
endpackage
`default_nettype wire

>>> rtl/ssc_mul.sv
// Pipelined unsigned multiplier built from 32x32 partial products; registers the partial products, row sums and sum.
`default_nettype none
module ssc_mul (
   input  wire logic                 clock,
   input  wire logic [ssc_pkg::MW-1:0] x,
   input  wire logic [ssc_pkg::MW-1:0] y,
   output logic      [ssc_pkg::PW-1:0] p
);
   import ssc_pkg::*;

   logic [2*CW-1:0] pp_ff [LIMBS][LIMBS];
   logic [PW-1:0]   row_in [LIMBS];
   logic [PW-1:0]   row_ff [LIMBS];
   logic [PW-1:0]   p_in;
   logic [PW-1:0]   p_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            pp_ff[i][j] <= (2*CW)'(x[CW*i +: CW]) * (2*CW)'(y[CW*j +: CW]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < LIMBS; j++) begin
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) << (CW * j));
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < LIMBS; i++) begin
         p_in = p_in + (row_ff[i] << (CW * i));
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      p_ff   <= p_in;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

>>> rtl/ssc_step.sv
// One bit of both root searches: trial step of entry and exit parameter.
`default_nettype none
module ssc_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ssc_pkg::KW-1:0] k,
   input  wire ssc_pkg::step_type     d_in,
   output ssc_pkg::step_type          d_out
);
   import ssc_pkg::*;

   logic signed [SW-1:0] ak;
   logic signed [SW-1:0] hs_c, fs_c, he_c, fe_c;
   logic [30:0]          inc;
   logic                 ok_s, ok_e;
   step_type             nxt;
   step_type             d_out_ff;

   always_comb begin
      ak   = d_in.a <<< k;
      hs_c = d_in.hs + ak;
      fs_c = d_in.fs + (((d_in.hs <<< 1) + ak) <<< k);
      he_c = d_in.he - ak;
      fe_c = d_in.fe - (((d_in.he <<< 1) - ak) <<< k);
      inc  = 31'(1) << k;
      // entry side walks up from 0, exit side walks down from 1.0
      ok_s = !d_in.ts[30] && (hs_c[SW-1] || hs_c == '0) && !fs_c[SW-1];
      ok_e = !d_in.te[30] && !he_c[SW-1] && !fe_c[SW-1];
      nxt  = d_in;
      if (ok_s) begin
         nxt.hs = hs_c;
         nxt.fs = fs_c;
         nxt.ts = d_in.ts | inc;
      end
      if (ok_e) begin
         nxt.he = he_c;
         nxt.fe = fe_c;
         nxt.te = d_in.te | inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_out_ff <= '0;
      end else begin
         d_out_ff <= nxt;
      end
   end

   assign d_out = d_out_ff;
endmodule
`default_nettype wire

>>> rtl/segment_sphere_clip_core.sv
// Top level: segment/sphere clip pipeline with register port.
`default_nettype none
// Clips the segment from b (parameter 0) to a (parameter 1) against a ball of
// radius 1/inverse_radius centered at the origin and reports the inside part
// as a Q2.30 interval, rounded outward. A transaction is taken whenever start
// is high and busy is low; busy is only high during reset, so a new transaction
// can enter every cycle. Each result appears on the rsp_ ports for one cycle
// with rsp_valid, in request order; the receiver cannot stall the pipe. The
// pipe depth is set by the exact arithmetic: four stages of coordinate
// capture, differences, products and sums, two rounds of three-stage wide
// multipliers (scaling by the squared inverse radius, then the discriminant
// test), a coefficient stage between them, one seed stage and 31
// bit-per-stage root searches that run entry and exit side in parallel, plus
// the output register.
// Registers (inverse_radius, cylinder_mode) are written through csr_ and
// may only change while no transaction is in flight.
module segment_sphere_clip_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_point_a_x,
   input  wire logic signed [31:0] req_point_a_y,
   input  wire logic signed [31:0] req_point_a_z,
   input  wire logic signed [31:0] req_point_b_x,
   input  wire logic signed [31:0] req_point_b_y,
   input  wire logic signed [31:0] req_point_b_z,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_start_param,
   output logic signed [31:0]      rsp_end_param,
   output logic                    rsp_hit,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import ssc_pkg::*;

   localparam int LAT = 13 + STEPS;

   typedef struct packed {
      logic        valid;
      logic        b_neg;
      logic [65:0] a0;
   } mid_type;

   typedef struct packed {
      logic                valid;
      logic                a_in;
      logic                b_in;
      logic [130:0]        a;
      logic signed [130:0] b;
      logic signed [130:0] c;
      logic [65:0]         a0;
   } hold_type;

   // registers
   logic [31:0] inv_radius_ff;
   logic        cyl_mode_ff;
   logic [63:0] ksq_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_radius_ff <= INV_RADIUS_RESET;
         cyl_mode_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_INV_RADIUS: inv_radius_ff <= csr_data;
            REG_CYL_MODE:   cyl_mode_ff   <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // K^2, recomputed every cycle; settles long before any transaction needs it
   always_ff @(posedge clock) begin
      ksq_ff <= 64'(inv_radius_ff) * 64'(inv_radius_ff);
   end

   logic accept;
   assign accept = start && !busy;

   // stage 1: capture, cylinder mode drops z
   logic               s1_valid_ff;
   logic signed [31:0] s1_a_ff [3];
   logic signed [31:0] s1_b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_a_ff[0] <= req_point_a_x;
         s1_a_ff[1] <= req_point_a_y;
         s1_a_ff[2] <= cyl_mode_ff ? '0 : req_point_a_z;
         s1_b_ff[0] <= req_point_b_x;
         s1_b_ff[1] <= req_point_b_y;
         s1_b_ff[2] <= cyl_mode_ff ? '0 : req_point_b_z;
      end
   end

   // stage 2: direction d = a - b in raw coordinate units
   logic               s2_valid_ff;
   logic signed [32:0] s2_d_ff [3];
   logic signed [31:0] s2_a_ff [3];
   logic signed [31:0] s2_b_ff [3];

   // stage 3: per-axis products
   logic               s3_valid_ff;
   logic [65:0]        s3_dd_ff [3];
   logic signed [64:0] s3_db_ff [3];
   logic [63:0]        s3_bb_ff [3];
   logic [63:0]        s3_aa_ff [3];

   // stage 4: dot products, still without K^2
   logic               s4_valid_ff;
   logic [65:0]        s4_a0_ff;
   logic signed [65:0] s4_b0_ff;
   logic [63:0]        s4_sb0_ff;
   logic [63:0]        s4_sa0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s2_d_ff[i]  <= 33'(s1_a_ff[i]) - 33'(s1_b_ff[i]);
         s2_a_ff[i]  <= s1_a_ff[i];
         s2_b_ff[i]  <= s1_b_ff[i];
         s3_dd_ff[i] <= $unsigned(66'(s2_d_ff[i]) * 66'(s2_d_ff[i]));
         s3_db_ff[i] <= 65'(s2_d_ff[i]) * 65'(s2_b_ff[i]);
         s3_bb_ff[i] <= $unsigned(64'(s2_b_ff[i]) * 64'(s2_b_ff[i]));
         s3_aa_ff[i] <= $unsigned(64'(s2_a_ff[i]) * 64'(s2_a_ff[i]));
      end
      s4_a0_ff  <= s3_dd_ff[0] + s3_dd_ff[1] + s3_dd_ff[2];
      s4_b0_ff  <= 66'(s3_db_ff[0]) + 66'(s3_db_ff[1]) + 66'(s3_db_ff[2]);
      s4_sb0_ff <= s3_bb_ff[0] + s3_bb_ff[1] + s3_bb_ff[2];
      s4_sa0_ff <= s3_aa_ff[0] + s3_aa_ff[1] + s3_aa_ff[2];
   end

   // stages 5..7: scale by K^2 and form the Cauchy-Schwarz terms
   logic [65:0]   b0_mag;
   logic [PW-1:0] pa_p, pb_p, psb_p, psa_p, pbb_p, pas_p;

   assign b0_mag = s4_b0_ff[65] ? $unsigned(-s4_b0_ff) : $unsigned(s4_b0_ff);

   ssc_mul u_mul_a (.clock(clock), .x(MW'(s4_a0_ff)), .y(MW'(ksq_ff)), .p(pa_p));
   ssc_mul u_mul_b (.clock(clock), .x(MW'(b0_mag)), .y(MW'(ksq_ff)), .p(pb_p));
   ssc_mul u_mul_sb (.clock(clock), .x(MW'(s4_sb0_ff)), .y(MW'(ksq_ff)), .p(psb_p));
   ssc_mul u_mul_sa (.clock(clock), .x(MW'(s4_sa0_ff)), .y(MW'(ksq_ff)), .p(psa_p));
   ssc_mul u_mul_bb (.clock(clock), .x(MW'(b0_mag)), .y(MW'(b0_mag)), .p(pbb_p));
   ssc_mul u_mul_as (.clock(clock), .x(MW'(s4_a0_ff)), .y(MW'(s4_sb0_ff)), .p(pas_p));

   mid_type mid_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) mid_ff[i] <= '0;
      end else begin
         mid_ff[0] <= '{valid: s4_valid_ff, b_neg: s4_b0_ff[65], a0: s4_a0_ff};
         mid_ff[1] <= mid_ff[0];
         mid_ff[2] <= mid_ff[1];
      end
   end

   // stage 8: quadratic coefficients and inside tests
   localparam logic [127:0] UNIT80 = 128'(1) << 80;

   hold_type      s8_in, s8_ff;
   logic [129:0]  e_in, s8_e_ff;

   always_comb begin
      s8_in.valid = mid_ff[2].valid;
      s8_in.a_in  = psa_p[127:0] <= UNIT80;
      s8_in.b_in  = psb_p[127:0] <= UNIT80;
      s8_in.a     = pa_p[130:0];
      s8_in.b     = mid_ff[2].b_neg ? -$signed({2'b00, pb_p[128:0]})
                                    : $signed({2'b00, pb_p[128:0]});
      s8_in.c     = $signed({3'b000, psb_p[127:0]}) - $signed({3'b000, UNIT80});
      s8_in.a0    = mid_ff[2].a0;
      // a0*|b|^2 - (d.b)^2, never negative
      e_in        = pas_p[129:0] - pbb_p[129:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ff <= '0;
      end else begin
         s8_ff <= s8_in;
      end
      s8_e_ff <= e_in;
   end

   // stages 9..11: discriminant sign needs K^2 * E against 2^80 * a0
   logic [PW-1:0] pdisc_p;
   hold_type      hold_ff [3];

   ssc_mul u_mul_disc (.clock(clock), .x(MW'(s8_e_ff)), .y(MW'(ksq_ff)), .p(pdisc_p));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) hold_ff[i] <= '0;
      end else begin
         hold_ff[0] <= s8_ff;
         hold_ff[1] <= hold_ff[0];
         hold_ff[2] <= hold_ff[1];
      end
   end

   // stage 12: case decision and search seeds at t = 0 and t = 1.0
   logic signed [SW-1:0] a_s, b_s, c_s, ab_s;
   logic                 disc_ok;
   step_type             seed;
   step_type             chain [STEPS+1];
   step_type             seed_ff;

   always_comb begin
      a_s     = SW'($signed({1'b0, hold_ff[2].a}));
      b_s     = SW'(hold_ff[2].b);
      c_s     = SW'(hold_ff[2].c);
      ab_s    = a_s + b_s;
      disc_ok = pdisc_p <= (PW'(hold_ff[2].a0) << 80);
      seed.valid       = hold_ff[2].valid;
      seed.cs.a_in     = hold_ff[2].a_in;
      seed.cs.b_in     = hold_ff[2].b_in;
      // both ends outside: chord counts only with both roots in [0,1]
      seed.cs.both_hit = (hold_ff[2].a != '0)
                         && (hold_ff[2].b[130] || hold_ff[2].b == '0)
                         && !ab_s[SW-1] && disc_ok;
      seed.a  = a_s;
      seed.hs = b_s <<< 30;
      seed.fs = c_s <<< 60;
      seed.ts = '0;
      seed.he = ab_s <<< 30;
      seed.fe = (a_s + (b_s <<< 1) + c_s) <<< 60;
      seed.te = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed;
      end
   end

   assign chain[0] = seed_ff;

   // one result bit per stage, MSB first
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      ssc_step u_step (
         .clock(clock),
         .reset(reset),
         .k    (KW'(STEPS - 1 - i)),
         .d_in (chain[i]),
         .d_out(chain[i+1])
      );
   end

   // output register
   step_type    fin;
   logic [31:0] start_in, end_in;
   logic        hit_in;

   always_comb begin
      fin = chain[STEPS];
      if (fin.cs.a_in && fin.cs.b_in) begin
         start_in = '0;
         end_in   = ONE_Q30;
         hit_in   = 1'b1;
      end else if (fin.cs.a_in || fin.cs.b_in) begin
         start_in = fin.cs.b_in ? '0 : 32'(fin.ts);
         end_in   = fin.cs.a_in ? ONE_Q30 : ONE_Q30 - 32'(fin.te);
         hit_in   = 1'b1;
      end else if (fin.cs.both_hit) begin
         start_in = 32'(fin.ts);
         end_in   = ONE_Q30 - 32'(fin.te);
         hit_in   = 1'b1;
      end else begin
         start_in = NO_HIT;
         end_in   = NO_HIT;
         hit_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= fin.valid;
      end
      rsp_start_param <= $signed(start_in);
      rsp_end_param   <= $signed(end_in);
      rsp_hit         <= hit_in;
   end

   // checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transaction did not come out after the pipeline latency");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_start_param <= rsp_end_param))
      else $error("interval entry lies past its exit");

   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |->
         (rsp_start_param >= 0 && rsp_end_param <= $signed(ONE_Q30)))
      else $error("interval outside the segment");

   a_nohit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_start_param == $signed(NO_HIT) && rsp_end_param == $signed(NO_HIT)))
      else $error("miss without the no-hit marker");
endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for segment_sphere_clip_core: random and directed segments, checked per result.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import ssc_pkg::*;

   typedef logic signed [319:0] wide_type;

   localparam logic [7:0] REG_UNMAPPED = 8'd7;  // no register at this index
   localparam int PIPE_DRAIN = 60;             // longer than the pipeline latency

   typedef struct {
      logic [31:0] start_p;
      logic [31:0] end_p;
      logic        hit;
   } interval_type;

   // Holds the clip intervals still owed by the pipe, in request order.
   class clip_scoreboard;
      logic [31:0]  inv_radius = INV_RADIUS_RESET;
      logic         cyl_mode = 1'b0;
      interval_type pending[$];
      int           errors = 0;
      int           n_checked = 0;
      int           n_hits = 0;
      int           n_partial = 0;

      // h = A t + B, f = (h + B) t + C, with B and C already scaled
      function automatic void quad_at(wide_type qa, wide_type qb, wide_type qc, longint t,
                                      output wide_type h, output wide_type f);
         wide_type tw;
         tw = t;
         h = qa * tw + qb;
         f = (h + qb) * tw + qc;
      endfunction

      function automatic longint entry_root(wide_type qa, wide_type qb, wide_type qc);
         longint lo, hi, mid;
         wide_type h, f;
         lo = 0;
         hi = ONE_Q30;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            quad_at(qa, qb, qc, mid, h, f);
            if (h <= 0 && f >= 0) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function automatic longint exit_root(wide_type qa, wide_type qb, wide_type qc);
         longint lo, hi, mid;
         wide_type h, f;
         lo = 0;
         hi = ONE_Q30;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            quad_at(qa, qb, qc, mid, h, f);
            if (h >= 0 && f >= 0) hi = mid;
            else lo = mid + 1;
         end
         return lo;
      endfunction

      function void note(logic signed [31:0] ax, ay, az, bx, by, bz);
         wide_type k, va, vb, vd, sa, sb, dd, db, unit, qb, qc, disc;
         logic signed [31:0] ca[3], cb[3];
         logic a_in, b_in;
         interval_type r;
         ca = '{ax, ay, az};
         cb = '{bx, by, bz};
         if (cyl_mode) begin
            ca[2] = 0;
            cb[2] = 0;
         end
         k = 0;
         k[31:0] = inv_radius;
         sa = 0; sb = 0; dd = 0; db = 0;
         for (int i = 0; i < 3; i++) begin
            va = ca[i];
            vb = cb[i];
            va = va * k;
            vb = vb * k;
            vd = va - vb;
            sa += va * va;
            sb += vb * vb;
            dd += vd * vd;
            db += vd * vb;
         end
         unit = 1;
         unit = unit <<< 80;
         a_in = (sa <= unit);
         b_in = (sb <= unit);
         qb = db <<< 30;
         qc = (sb - unit) <<< 60;
         r = '{NO_HIT, NO_HIT, 1'b0};
         if (a_in && b_in) begin
            r = '{32'd0, ONE_Q30, 1'b1};
         end else if (a_in || b_in) begin
            r.start_p = b_in ? 32'd0 : 32'(entry_root(dd, qb, qc));
            r.end_p = a_in ? ONE_Q30 : 32'(exit_root(dd, qb, qc));
            r.hit = 1'b1;
            n_partial++;
         end else begin
            disc = db * db - dd * (sb - unit);
            if (dd != 0 && db <= 0 && dd + db >= 0 && disc >= 0) begin
               r.start_p = 32'(entry_root(dd, qb, qc));
               r.end_p = 32'(exit_root(dd, qb, qc));
               r.hit = 1'b1;
            end
         end
         if (r.hit) n_hits++;
         pending.push_back(r);
      endfunction

      function void check(logic [31:0] s, logic [31:0] e, logic h);
         interval_type x;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result start=%h end=%h hit=%b", $time, s, e, h);
            errors++;
            return;
         end
         x = pending.pop_front();
         n_checked++;
         if (s !== x.start_p) begin
            $display("%0t: start_param expected %h actual %h", $time, x.start_p, s);
            errors++;
         end
         if (e !== x.end_p) begin
            $display("%0t: end_param expected %h actual %h", $time, x.end_p, e);
            errors++;
         end
         if (h !== x.hit) begin
            $display("%0t: hit expected %b actual %b", $time, x.hit, h);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic signed [31:0] req_point_a_x, req_point_a_y, req_point_a_z;
   logic signed [31:0] req_point_b_x, req_point_b_y, req_point_b_z;
   logic rsp_valid;
   logic signed [31:0] rsp_start_param, rsp_end_param;
   logic rsp_hit;
   logic csr_valid;
   logic csr_ready;
   logic [7:0] csr_index;
   logic [31:0] csr_data;

   clip_scoreboard sb = new();

   segment_sphere_clip_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: requests and results are sampled on the same edge that moves them.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note(req_point_a_x, req_point_a_y, req_point_a_z,
                 req_point_b_x, req_point_b_y, req_point_b_z);
      if (!reset && rsp_valid)
         sb.check(rsp_start_param, rsp_end_param, rsp_hit);
   end

   // Ball radius in Q16.16 units for the current inverse radius, clamped to 31 bits.
   function automatic longint radius_units();
      longint r;
      if (sb.inv_radius == 0) return 64'h7FFF_FFFF;
      r = (64'd1 << 40) / longint'(sb.inv_radius);
      return (r > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : r;
   endfunction

   // Mostly near the ball surface so all clip cases show up; sometimes any 32-bit value.
   function automatic logic signed [31:0] rand_coord();
      longint r, span;
      int mode;
      r = radius_units();
      mode = $urandom_range(0, 9);
      if (mode == 0) return $urandom();
      span = (mode < 4) ? r : (mode < 8) ? 2 * r : r / 2 + 1;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      return 32'(longint'($urandom_range(0, 32'(2 * span))) - span);
   endfunction

   // One request; start stays high into the next one when the gap is zero.
   task automatic send_segment(logic signed [31:0] ax, ay, az, bx, by, bz);
      int gap;
      req_point_a_x <= ax;
      req_point_a_y <= ay;
      req_point_a_z <= az;
      req_point_b_x <= bx;
      req_point_b_y <= by;
      req_point_b_z <= bz;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;  // back-to-back bursts
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Halt requests and let every pending transaction drain.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_INV_RADIUS) sb.inv_radius = value;
      else if (idx == REG_CYL_MODE) sb.cyl_mode = value[0];
      @(posedge clock);
   endtask

   task automatic set_mode(logic [31:0] k, logic [31:0] cyl);
      drain();
      write_csr(REG_INV_RADIUS, k);
      write_csr(REG_CYL_MODE, cyl);
   endtask

   task automatic random_segments(int n);
      logic signed [31:0] ax, ay, az;
      repeat (n) begin
         ax = rand_coord();
         ay = rand_coord();
         az = rand_coord();
         if ($urandom_range(0, 15) == 0)
            send_segment(ax, ay, az, ax, ay, az);   // degenerate segment
         else
            send_segment(ax, ay, az, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   localparam logic signed [31:0] R1 = 32'sh0001_0000;  // radius at inverse radius 1.0
   localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_point_a_x <= '0;
      req_point_a_y <= '0;
      req_point_a_z <= '0;
      req_point_b_x <= '0;
      req_point_b_y <= '0;
      req_point_b_z <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases at reset settings (unit ball).
      send_segment(0, 0, 0, 100, -100, 50);                // both inside
      send_segment(R1, 0, 0, 0, -R1, 0);                   // both on the surface
      send_segment(2 * R1, 0, 0, 0, 0, 0);                 // only b inside
      send_segment(0, 0, 0, 0, 0, -3 * R1);                // only a inside
      send_segment(-2 * R1, 0, 0, 2 * R1, 0, 0);           // chord through center
      send_segment(-2 * R1, 2 * R1, 0, 2 * R1, 2 * R1, 0); // clean miss
      send_segment(R1, -2 * R1, 0, R1, 2 * R1, 0);         // tangent
      send_segment(3 * R1, 0, 0, 3 * R1, 0, 0);            // coincident, outside
      send_segment(2 * R1, 0, 0, 4 * R1, 0, 0);            // outside, line would hit
      send_segment(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);    // field extremes
      send_segment(SMIN, 0, SMAX, 0, SMIN, 0);
      send_segment(-1, -1, -1, 1, 1, 1);
      send_segment(0, 0, 5 * R1, 0, 0, -5 * R1);           // along z
      drain();
      write_csr(REG_UNMAPPED, 32'hFFFF_FFFF);              // must be ignored
      random_segments(60);

      // Zero inverse radius: everything is inside.
      set_mode(32'd0, 32'd0);
      send_segment(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
      random_segments(40);

      // Largest inverse radius, cylinder with junk in the upper bits.
      set_mode(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_segment(0, 0, SMAX, 0, 0, SMIN);
      random_segments(70);

      // Unit radius cylinder; z is ignored.
      set_mode(INV_RADIUS_RESET, 32'd1);
      send_segment(0, 0, 9 * R1, 3 * R1, 0, -9 * R1);
      random_segments(70);

      // Upper bits set on mode write: back to sphere.
      set_mode(32'h0000_0001, 32'hFFFF_FFFE);
      random_segments(50);

      // Random settings.
      repeat (3) begin
         set_mode((32'd1 << $urandom_range(8, 31)) | ($urandom() & 32'h00FF_FFFF),
                  $urandom_range(0, 1));
         random_segments(50);
      end

      drain();
      $display("Checked %0d clip results (%0d hits, %0d with one end inside)",
               sb.n_checked, sb.n_hits, sb.n_partial);
      $display("over sphere and cylinder modes, zero, unit, extreme and random radii.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results outstanding", sb.pending.size());
      $display("Mismatches found");
      $finish;
   end
endmodule

`default_nettype wire

>>> sim.f
rtl/ssc_pkg.sv
rtl/ssc_mul.sv
rtl/ssc_step.sv
rtl/segment_sphere_clip_core.sv
dv/tb.sv
